// ===== rtl/assert_macros.svh =====
// assertion helpers used by the graham_scan_convex_hull rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define GS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gsch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsch_pkg
// Types, widths and helpers for the graham scan convex hull block.
// ----------------------------------------------------------------------------
package gsch_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 32;

	localparam int IDX_W   = $clog2(MAX_POINTS);
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int PT_W    = 2 * COORD_BITS;
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int DIST_W  = COORD_BITS + 2;
	localparam int DATA_W  = 64;
	localparam int USER_W  = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [CROSS_W-1:0]    cross_t;
	typedef logic [DIST_W-1:0]            dist_t;

	typedef enum logic [5:0] {
		ST_LOAD,
		ST_START,
		SRT_RD_I,
		SRT_GET_I,
		SRT_RD_ORD,
		SRT_GET_ORD,
		SRT_GET_B,
		SRT_DEC,
		SRT_INS,
		SRT_NEXT,
		CR_M1,
		CR_M2,
		CR_CMP,
		HS_INIT,
		E_GET0,
		E_GETA,
		E_CHK,
		E_GETORD,
		E_GETB,
		E_DEC,
		RV_INIT,
		RV_CHK,
		RV_RDJ,
		RV_WJ,
		RV_WI,
		SC_INIT,
		SC_INIT2,
		SC_CHK,
		SC_GETN,
		SC_GETNB,
		SC_GETT,
		SC_GETTP,
		SC_GETU,
		SC_GETUP,
		SC_DEC,
		SC_PUSH,
		EM_START,
		EM_RD,
		EM_GETS,
		EM_GETP,
		EM_EMPTY,
		EM_WAIT
	} state_t;

	function automatic diff_t sub_d(coord_t a, coord_t b);
		diff_t da;
		diff_t db;
		da = DIFF_W'(a);
		db = DIFF_W'(b);
		return da - db;
	endfunction

	function automatic logic [DIFF_W-1:0] abs_d(diff_t d);
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

endpackage

// ===== rtl/gsch_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsch_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module gsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/graham_scan_convex_hull.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graham_scan_convex_hull
// Convex hull of a point set by graham scan, emitted counter-clockwise.
// ----------------------------------------------------------------------------
// Points load at one per cycle into a point ram, tracking the pivot on the
// fly; the point carrying tlast starts the hull and s_tready stays low until
// the last hull vertex has been taken. The hull pass runs on one shared
// 33x33 multiplier, the two products of each cross product taken in turn:
// first the insertion sort, then the same-ray walk, the stack scan and the
// emission of the vertices, the last bounded by the single read port of
// the point ram. Sets of fewer than three points, or with fewer than three
// hull vertices, give one transaction flagged empty.
`include "assert_macros.svh"

module graham_scan_convex_hull import gsch_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // point_x, point_y
	input  logic              s_tlast,  // is_last
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // hull_x, hull_y
	output logic              m_tlast,  // hull_last
	output logic [USER_W-1:0] m_tuser   // hull_empty, overflowed
);

	state_t state_q, state_d, ret_q;

	logic [CNT_W-1:0] cnt_q, ii_q, kk_q, mm_q, ee_q, dep_q;
	logic             ovf_q;
	logic [IDX_W-1:0] piv_q, bidx_q, nidx_q, ti_q;
	coord_t           pvx_q, pvy_q, ox_q, oy_q, ax_q, ay_q, bx_q, by_q;
	prod_t            prod1_q, prod2_q;
	logic             neg_q, zero_q, dgt_q;

	logic             out_valid_q, out_last_q, out_empty_q, out_ovf_q;
	coord_t           out_x_q, out_y_q;

	// ram ports
	logic             pt_we;
	logic [IDX_W-1:0] pt_waddr, pt_raddr;
	logic [PT_W-1:0]  pt_wdata, pt_rdata;
	logic             ord_we;
	logic [IDX_W-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
	logic             stk_we;
	logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

	coord_t in_x, in_y, rx, ry;
	diff_t  mul_a, mul_b;
	prod_t  mul_p;
	cross_t crs;
	dist_t  dist_a, dist_b;
	logic   s_acc, m_acc, has_room, goes_first;

	assign in_x     = coord_t'(s_tdata[COORD_BITS-1:0]);
	assign in_y     = coord_t'(s_tdata[32+COORD_BITS-1:32]);
	assign rx       = coord_t'(pt_rdata[COORD_BITS-1:0]);
	assign ry       = coord_t'(pt_rdata[PT_W-1:COORD_BITS]);
	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = out_valid_q && m_tready;
	assign has_room = cnt_q < CNT_W'(MAX_POINTS);
	assign goes_first = (!neg_q && !zero_q) || (zero_q && dgt_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {32'(out_y_q), 32'(out_x_q)};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_ovf_q, out_empty_q};

	// shared multiplier, two products per cross
	always_comb begin
		if (state_q == CR_M1) begin
			mul_a = sub_d(ax_q, ox_q);
			mul_b = sub_d(by_q, oy_q);
		end else begin
			mul_a = sub_d(bx_q, ox_q);
			mul_b = sub_d(ay_q, oy_q);
		end
		mul_p = mul_a * mul_b;
	end

	assign crs    = CROSS_W'(prod1_q) - CROSS_W'(prod2_q);
	assign dist_a = DIST_W'(abs_d(sub_d(ax_q, ox_q))) + DIST_W'(abs_d(sub_d(ay_q, oy_q)));
	assign dist_b = DIST_W'(abs_d(sub_d(bx_q, ox_q))) + DIST_W'(abs_d(sub_d(by_q, oy_q)));

	gsch_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	gsch_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_ord_ram (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	gsch_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram control
	always_comb begin
		state_d   = state_q;
		pt_we     = 1'b0;
		pt_waddr  = cnt_q[IDX_W-1:0];
		pt_wdata  = {in_y, in_x};
		pt_raddr  = '0;
		ord_we    = 1'b0;
		ord_waddr = kk_q[IDX_W-1:0];
		ord_wdata = bidx_q;
		ord_raddr = '0;
		stk_we    = 1'b0;
		stk_waddr = dep_q[IDX_W-1:0];
		stk_wdata = nidx_q;
		stk_raddr = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (s_acc) begin
					pt_we = has_room;
					if (s_tlast) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: state_d = (cnt_q < CNT_W'(3)) ? EM_EMPTY : SRT_RD_I;
			SRT_RD_I: begin
				pt_raddr = ii_q[IDX_W-1:0];
				state_d  = SRT_GET_I;
			end
			SRT_GET_I: begin
				// copies of the pivot stay out of the angle order
				if (ii_q[IDX_W-1:0] == piv_q || (rx == pvx_q && ry == pvy_q)) begin
					state_d = SRT_NEXT;
				end else if (mm_q == '0) begin
					state_d = SRT_INS;
				end else begin
					state_d = SRT_RD_ORD;
				end
			end
			SRT_RD_ORD: begin
				ord_raddr = IDX_W'(kk_q - CNT_W'(1));
				state_d   = SRT_GET_ORD;
			end
			SRT_GET_ORD: begin
				pt_raddr = ord_rdata;
				state_d  = SRT_GET_B;
			end
			SRT_GET_B: state_d = CR_M1;
			CR_M1:     state_d = CR_M2;
			CR_M2:     state_d = CR_CMP;
			CR_CMP:    state_d = ret_q;
			SRT_DEC: begin
				if (goes_first) begin
					ord_we  = 1'b1;
					state_d = (kk_q == CNT_W'(1)) ? SRT_INS : SRT_RD_ORD;
				end else begin
					state_d = SRT_INS;
				end
			end
			SRT_INS: begin
				ord_we    = 1'b1;
				ord_wdata = ii_q[IDX_W-1:0];
				state_d   = SRT_NEXT;
			end
			SRT_NEXT: state_d = (ii_q == cnt_q - CNT_W'(1)) ? HS_INIT : SRT_RD_I;
			HS_INIT: begin
				stk_we    = 1'b1;
				stk_waddr = '0;
				stk_wdata = piv_q;
				ord_raddr = '0;
				state_d   = (mm_q == '0) ? EM_START : E_GET0;
			end
			E_GET0: begin
				pt_raddr = ord_rdata;
				state_d  = E_GETA;
			end
			E_GETA: state_d = E_CHK;
			E_CHK: begin
				ord_raddr = ee_q[IDX_W-1:0];
				state_d   = (ee_q == mm_q) ? RV_INIT : E_GETORD;
			end
			E_GETORD: begin
				pt_raddr = ord_rdata;
				state_d  = E_GETB;
			end
			E_GETB:  state_d = CR_M1;
			E_DEC:   state_d = zero_q ? E_CHK : RV_INIT;
			RV_INIT: state_d = RV_CHK;
			RV_CHK: begin
				ord_raddr = ii_q[IDX_W-1:0];
				state_d   = (ii_q < kk_q) ? RV_RDJ : SC_INIT;
			end
			RV_RDJ: begin
				ord_raddr = kk_q[IDX_W-1:0];
				state_d   = RV_WJ;
			end
			RV_WJ: begin
				ord_we    = 1'b1;
				ord_waddr = ii_q[IDX_W-1:0];
				ord_wdata = ord_rdata;
				state_d   = RV_WI;
			end
			RV_WI: begin
				ord_we    = 1'b1;
				ord_wdata = ti_q;
				state_d   = RV_CHK;
			end
			SC_INIT: begin
				ord_raddr = '0;
				state_d   = SC_INIT2;
			end
			SC_INIT2: begin
				stk_we    = 1'b1;
				stk_waddr = IDX_W'(1);
				stk_wdata = ord_rdata;
				state_d   = SC_CHK;
			end
			SC_CHK: begin
				ord_raddr = ii_q[IDX_W-1:0];
				state_d   = (ii_q == mm_q) ? EM_START : SC_GETN;
			end
			SC_GETN: begin
				pt_raddr = ord_rdata;
				state_d  = SC_GETNB;
			end
			SC_GETNB: begin
				stk_raddr = IDX_W'(dep_q - CNT_W'(1));
				state_d   = SC_GETT;
			end
			SC_GETT: begin
				pt_raddr = stk_rdata;
				state_d  = SC_GETTP;
			end
			SC_GETTP: begin
				stk_raddr = IDX_W'(dep_q - CNT_W'(2));
				state_d   = SC_GETU;
			end
			SC_GETU: begin
				pt_raddr = stk_rdata;
				state_d  = SC_GETUP;
			end
			SC_GETUP: state_d = (dep_q <= CNT_W'(2)) ? SC_PUSH : CR_M1;
			SC_DEC:   state_d = neg_q ? SC_CHK : SC_PUSH;
			SC_PUSH: begin
				// a repeat of the top is skipped
				stk_we  = !(ax_q == bx_q && ay_q == by_q) && (dep_q < CNT_W'(MAX_POINTS));
				state_d = SC_CHK;
			end
			EM_START: state_d = (dep_q < CNT_W'(3)) ? EM_EMPTY : EM_RD;
			EM_RD: begin
				stk_raddr = ii_q[IDX_W-1:0];
				state_d   = EM_GETS;
			end
			EM_GETS: begin
				pt_raddr = stk_rdata;
				state_d  = EM_GETP;
			end
			EM_GETP:  state_d = EM_WAIT;
			EM_EMPTY: state_d = EM_WAIT;
			EM_WAIT: begin
				if (m_acc) begin
					state_d = out_last_q ? ST_LOAD : EM_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			ret_q       <= ST_LOAD;
			ii_q        <= '0;
			kk_q        <= '0;
			mm_q        <= '0;
			ee_q        <= '0;
			dep_q       <= '0;
			piv_q       <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (has_room) begin
							cnt_q <= cnt_q + CNT_W'(1);
							if (cnt_q == '0 || in_y < pvy_q || (in_y == pvy_q && in_x < pvx_q)) begin
								piv_q <= cnt_q[IDX_W-1:0];
							end
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_START: begin
					ii_q <= '0;
					mm_q <= '0;
				end
				SRT_GET_I: kk_q  <= mm_q;
				SRT_GET_B: ret_q <= SRT_DEC;
				SRT_DEC: begin
					if (goes_first) begin
						kk_q <= kk_q - CNT_W'(1);
					end
				end
				SRT_INS:  mm_q  <= mm_q + CNT_W'(1);
				SRT_NEXT: ii_q  <= ii_q + CNT_W'(1);
				HS_INIT:  dep_q <= CNT_W'(1);
				E_GETA:   ee_q  <= CNT_W'(1);
				E_GETB:   ret_q <= E_DEC;
				E_DEC: begin
					if (zero_q) begin
						ee_q <= ee_q + CNT_W'(1);
					end
				end
				RV_INIT: begin
					ii_q <= '0;
					kk_q <= ee_q - CNT_W'(1);
				end
				RV_WI: begin
					ii_q <= ii_q + CNT_W'(1);
					kk_q <= kk_q - CNT_W'(1);
				end
				SC_INIT2: begin
					dep_q <= CNT_W'(2);
					ii_q  <= CNT_W'(1);
				end
				SC_GETUP: ret_q <= SC_DEC;
				SC_DEC: begin
					if (neg_q) begin
						dep_q <= dep_q - CNT_W'(1);
					end
				end
				SC_PUSH: begin
					if (stk_we) begin
						dep_q <= dep_q + CNT_W'(1);
					end
					ii_q <= ii_q + CNT_W'(1);
				end
				EM_START: ii_q        <= '0;
				EM_GETP:  out_valid_q <= 1'b1;
				EM_EMPTY: out_valid_q <= 1'b1;
				EM_WAIT: begin
					if (m_acc) begin
						out_valid_q <= 1'b0;
						ii_q        <= ii_q + CNT_W'(1);
						if (out_last_q) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				if (s_acc && has_room &&
				    (cnt_q == '0 || in_y < pvy_q || (in_y == pvy_q && in_x < pvx_q))) begin
					pvx_q <= in_x;
					pvy_q <= in_y;
				end
			end
			ST_START: begin
				ox_q <= pvx_q;
				oy_q <= pvy_q;
			end
			SRT_GET_I: begin
				ax_q <= rx;
				ay_q <= ry;
			end
			SRT_GET_ORD: bidx_q <= ord_rdata;
			SRT_GET_B, E_GETB, SC_GETNB: begin
				bx_q <= rx;
				by_q <= ry;
			end
			CR_M1: prod1_q <= mul_p;
			CR_M2: prod2_q <= mul_p;
			CR_CMP: begin
				neg_q  <= crs[CROSS_W-1];
				zero_q <= (crs == '0);
				dgt_q  <= dist_a > dist_b;
			end
			E_GETA, SC_GETTP: begin
				ax_q <= rx;
				ay_q <= ry;
			end
			RV_RDJ:  ti_q   <= ord_rdata;
			SC_GETN: nidx_q <= ord_rdata;
			SC_GETUP: begin
				ox_q <= rx;
				oy_q <= ry;
			end
			EM_GETP: begin
				out_x_q     <= rx;
				out_y_q     <= ry;
				out_last_q  <= (ii_q == dep_q - CNT_W'(1));
				out_empty_q <= 1'b0;
				out_ovf_q   <= ovf_q;
			end
			EM_EMPTY: begin
				out_x_q     <= '0;
				out_y_q     <= '0;
				out_last_q  <= 1'b1;
				out_empty_q <= 1'b1;
				out_ovf_q   <= ovf_q;
			end
			default: ;
		endcase
	end

	`GS_ASSERT_IMPL(a_depth_cap, 1'b1, dep_q <= CNT_W'(MAX_POINTS), "hull stack past capacity")
	`GS_ASSERT_IMPL(a_count_cap, 1'b1, cnt_q <= CNT_W'(MAX_POINTS), "point count past capacity")
	`GS_ASSERT_IMPL(a_no_load_out, s_tready, !m_tvalid, "loading while a vertex is pending")
	`GS_ASSERT_IMPL(a_empty_last, m_tvalid && m_tuser[0], m_tlast, "empty result not last")
	`GS_ASSERT_NEXT(a_set_cleared, m_tvalid && m_tready && m_tlast, cnt_q == '0 && !ovf_q,
		"set state not cleared after last transaction")

endmodule
